FILE: rtl/aode_pkg.sv
// shared constants, codes and types of the aode pair class counter
`default_nettype none
package aode_pkg;

   localparam int MAX_ATTRS   = 8;
   localparam int MAX_CARD    = 8;
   localparam int MAX_CLASSES = 4;
   localparam int COUNT_BITS  = 32;

   localparam int VALUE_W  = 16;
   localparam int OUT_W    = 32;
   localparam int REQ_W    = 2;
   localparam int LABEL_IN_W = 3;
   localparam int ADDR_IN_W  = 15;
   localparam int STATUS_W = 2;

   localparam int ATTR_W  = $clog2(MAX_ATTRS);
   localparam int VAL_W   = $clog2(MAX_CARD);
   localparam int CLS_W   = $clog2(MAX_CLASSES);
   localparam int NATTR_W = $clog2(MAX_ATTRS + 1);

   localparam int PAIR_DEPTH = MAX_ATTRS * MAX_CARD * MAX_ATTRS * MAX_CARD * MAX_CLASSES;
   localparam int ATTR_DEPTH = MAX_ATTRS * MAX_CARD * MAX_CLASSES;
   localparam int ALL_DEPTH  = PAIR_DEPTH + ATTR_DEPTH + MAX_CLASSES;
   localparam int PAIR_AW    = $clog2(PAIR_DEPTH);
   // attribute counts and class totals share one memory
   localparam int ATTR_RAM_DEPTH = 2 * ATTR_DEPTH;
   localparam int ATTR_AW    = $clog2(ATTR_RAM_DEPTH);

   // configuration register map
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;
   localparam int NUM_ATTR_W = 4;
   localparam int NUM_CLS_W  = 3;
   localparam int CARD_W     = 24;
   localparam int CARD_FIELD_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_ATTRIBUTES = 2'd0,
      CSR_NUM_CLASSES    = 2'd1,
      CSR_CARD_TABLE     = 2'd2
   } csr_idx_type;

   typedef enum logic [REQ_W-1:0] {
      REQ_ADD   = 2'd0,
      REQ_READ  = 2'd1,
      REQ_CLEAR = 2'd2,
      REQ_NOP   = 2'd3
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_BAD_LABEL = 2'd1,
      ST_BAD_ADDR  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      OP_ADD   = 3'd0,
      OP_READ  = 3'd1,
      OP_CLEAR = 3'd2,
      OP_NOP   = 3'd3,
      OP_DROP  = 3'd4
   } op_type;

   typedef struct packed {
      op_type                     op;
      logic [MAX_ATTRS*VAL_W-1:0] vals;
      logic [CLS_W-1:0]           label;
      logic [NATTR_W-1:0]         n;
      logic [ADDR_IN_W-1:0]       addr;
   } entry_type;

endpackage
`default_nettype wire

FILE: rtl/aode_if.sv
// request, response and register write channel interfaces
`default_nettype none
interface aode_req_if;
   logic                              valid;
   logic                              ready;
   logic [aode_pkg::REQ_W-1:0]        req_type;
   logic signed [aode_pkg::VALUE_W-1:0] value_0;
   logic signed [aode_pkg::VALUE_W-1:0] value_1;
   logic signed [aode_pkg::VALUE_W-1:0] value_2;
   logic signed [aode_pkg::VALUE_W-1:0] value_3;
   logic signed [aode_pkg::VALUE_W-1:0] value_4;
   logic signed [aode_pkg::VALUE_W-1:0] value_5;
   logic signed [aode_pkg::VALUE_W-1:0] value_6;
   logic signed [aode_pkg::VALUE_W-1:0] value_7;
   logic [aode_pkg::LABEL_IN_W-1:0]   sample_class;
   logic [aode_pkg::ADDR_IN_W-1:0]    read_addr;
   modport source (output valid, req_type, value_0, value_1, value_2, value_3, value_4,
                   value_5, value_6, value_7, sample_class, read_addr, input ready);
   modport sink (input valid, req_type, value_0, value_1, value_2, value_3, value_4,
                 value_5, value_6, value_7, sample_class, read_addr, output ready);
endinterface

interface aode_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [aode_pkg::OUT_W-1:0]      count;
   logic [aode_pkg::STATUS_W-1:0]   status;
   modport source (output valid, count, status, input ready);
   modport sink (input valid, count, status, output ready);
endinterface

interface aode_csr_if;
   logic                             valid;
   logic                             ready;
   logic [aode_pkg::CSR_IDX_W-1:0]   index;
   logic [aode_pkg::CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/aode_ram.sv
// generic simple dual port ram, registered read
`default_nettype none
module aode_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]              rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

FILE: rtl/aode_fifo.sv
// two entry queue between front and back
`default_nettype none
module aode_fifo (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire aode_pkg::entry_type push_entry,
   output logic                     full,
   input  wire logic                pop,
   output aode_pkg::entry_type      pop_entry,
   output logic                     empty
);
   aode_pkg::entry_type entry_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == 2'd2);
   assign empty     = (cnt_ff == 2'd0);
   assign pop_entry = entry_ff[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff ^ push;
      rptr_in = rptr_ff ^ pop;
      cnt_in  = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
      if (push) begin
         entry_ff[wptr_ff] <= push_entry;
      end
   end

   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("push into full queue");
   assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("queue count out of range");
endmodule
`default_nettype wire

FILE: rtl/aode_front.sv
// register file, request classification and value clamping
`default_nettype none
module aode_front (
   input  wire logic            clock,
   input  wire logic            reset,
   aode_req_if.sink             req,
   aode_csr_if.sink             csr,
   input  wire logic            fifo_full,
   input  wire logic            init_busy,
   output logic                 push,
   output aode_pkg::entry_type  push_entry
);
   logic [aode_pkg::NUM_ATTR_W-1:0] num_attr_ff;
   logic [aode_pkg::NUM_CLS_W-1:0]  num_cls_ff;
   logic [aode_pkg::CARD_W-1:0]     card_ff;
   logic signed [aode_pkg::VALUE_W-1:0] raw [aode_pkg::MAX_ATTRS];
   logic [aode_pkg::CARD_FIELD_W-1:0]   field;
   logic [aode_pkg::MAX_ATTRS*aode_pkg::VAL_W-1:0] vals;
   logic [aode_pkg::NATTR_W-1:0] n_use;
   logic label_bad;

   assign csr.ready = 1'b1;
   assign req.ready = !fifo_full && !init_busy;
   assign push      = req.valid && req.ready;

   assign raw[0] = req.value_0;
   assign raw[1] = req.value_1;
   assign raw[2] = req.value_2;
   assign raw[3] = req.value_3;
   assign raw[4] = req.value_4;
   assign raw[5] = req.value_5;
   assign raw[6] = req.value_6;
   assign raw[7] = req.value_7;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_attr_ff <= aode_pkg::NUM_ATTR_W'(8);
         num_cls_ff  <= aode_pkg::NUM_CLS_W'(4);
         card_ff     <= '1;
      end else if (csr.valid && csr.ready) begin
         case (csr.index)
            aode_pkg::CSR_NUM_ATTRIBUTES: num_attr_ff <= csr.data[aode_pkg::NUM_ATTR_W-1:0];
            aode_pkg::CSR_NUM_CLASSES:    num_cls_ff  <= csr.data[aode_pkg::NUM_CLS_W-1:0];
            aode_pkg::CSR_CARD_TABLE:     card_ff     <= csr.data[aode_pkg::CARD_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp each value to 0..cardinality-1
   always_comb begin
      vals  = '0;
      field = '0;
      for (int a = 0; a < aode_pkg::MAX_ATTRS; a++) begin
         field = card_ff[a*aode_pkg::CARD_FIELD_W +: aode_pkg::CARD_FIELD_W];
         if (raw[a][aode_pkg::VALUE_W-1]) begin
            vals[a*aode_pkg::VAL_W +: aode_pkg::VAL_W] = '0;
         end else if (raw[a][aode_pkg::VALUE_W-2:0] > (aode_pkg::VALUE_W-1)'(field)) begin
            vals[a*aode_pkg::VAL_W +: aode_pkg::VAL_W] = aode_pkg::VAL_W'(field);
         end else begin
            vals[a*aode_pkg::VAL_W +: aode_pkg::VAL_W] = raw[a][aode_pkg::VAL_W-1:0];
         end
      end
   end

   assign n_use = (num_attr_ff > aode_pkg::NUM_ATTR_W'(aode_pkg::MAX_ATTRS))
                  ? aode_pkg::NATTR_W'(aode_pkg::MAX_ATTRS)
                  : aode_pkg::NATTR_W'(num_attr_ff);
   assign label_bad = (req.sample_class >= num_cls_ff) ||
                      (req.sample_class >= aode_pkg::LABEL_IN_W'(aode_pkg::MAX_CLASSES));

   always_comb begin
      push_entry.vals  = vals;
      push_entry.label = req.sample_class[aode_pkg::CLS_W-1:0];
      push_entry.n     = n_use;
      push_entry.addr  = req.read_addr;
      unique case (req.req_type)
         aode_pkg::REQ_ADD:   push_entry.op = label_bad ? aode_pkg::OP_DROP : aode_pkg::OP_ADD;
         aode_pkg::REQ_READ:  push_entry.op = aode_pkg::OP_READ;
         aode_pkg::REQ_CLEAR: push_entry.op = aode_pkg::OP_CLEAR;
         default:             push_entry.op = aode_pkg::OP_NOP;
      endcase
   end
endmodule
`default_nettype wire

FILE: rtl/aode_back.sv
// count sequencer: read-modify-write of the count memories, reads and clears
`default_nettype none
module aode_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                fifo_empty,
   input  wire aode_pkg::entry_type pop_entry,
   output logic                     pop,
   output logic                     init_busy,
   aode_rsp_if.source               rsp
);
   localparam int CW = aode_pkg::COUNT_BITS;

   typedef enum logic [2:0] {
      S_INIT, S_IDLE, S_ADD, S_DRAIN, S_READ, S_CLEAR, S_DONE
   } state_type;

   state_type state_ff, state_in;
   aode_pkg::entry_type cur_ff, cur_in;
   logic [aode_pkg::ATTR_W-1:0]  pa_ff, pa_in, pb_ff, pb_in;
   logic [aode_pkg::NATTR_W-1:0] ai_ff, ai_in;
   logic prun_ff, prun_in, arun_ff, arun_in;
   logic pwb_v_ff, pwb_v_in, awb_v_ff, awb_v_in;
   logic [aode_pkg::PAIR_AW-1:0] pwb_addr_ff, pwb_addr_in;
   logic [aode_pkg::ATTR_AW-1:0] awb_addr_ff, awb_addr_in;
   logic [aode_pkg::PAIR_AW-1:0] sweep_ff, sweep_in;
   logic rd_pair_ff, rd_pair_in;
   logic [aode_pkg::OUT_W-1:0]    res_count_ff, res_count_in;
   aode_pkg::status_type          res_status_ff, res_status_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [aode_pkg::OUT_W-1:0]    rsp_count_ff, rsp_count_in;
   aode_pkg::status_type          rsp_status_ff, rsp_status_in;

   logic pair_we, attr_we, pair_re, attr_re;
   logic [aode_pkg::PAIR_AW-1:0] pair_waddr, pair_raddr;
   logic [aode_pkg::ATTR_AW-1:0] attr_waddr, attr_raddr;
   logic [CW-1:0] pair_wdata, attr_wdata, pair_rdata, attr_rdata;
   logic [aode_pkg::VAL_W-1:0] va, vb, vi;
   logic [aode_pkg::ATTR_W-1:0] n_last;
   logic p_last, a_last;

   aode_ram #(.WIDTH(CW), .DEPTH(aode_pkg::PAIR_DEPTH)) u_pair_ram (
      .clock(clock), .we(pair_we), .waddr(pair_waddr), .wdata(pair_wdata),
      .raddr(pair_raddr), .rdata(pair_rdata)
   );

   aode_ram #(.WIDTH(CW), .DEPTH(aode_pkg::ATTR_RAM_DEPTH)) u_attr_ram (
      .clock(clock), .we(attr_we), .waddr(attr_waddr), .wdata(attr_wdata),
      .raddr(attr_raddr), .rdata(attr_rdata)
   );

   assign init_busy  = (state_ff == S_INIT);
   assign rsp.valid  = rsp_valid_ff;
   assign rsp.count  = rsp_count_ff;
   assign rsp.status = rsp_status_ff;

   assign va = cur_ff.vals[pa_ff*aode_pkg::VAL_W +: aode_pkg::VAL_W];
   assign vb = cur_ff.vals[pb_ff*aode_pkg::VAL_W +: aode_pkg::VAL_W];
   assign vi = cur_ff.vals[ai_ff[aode_pkg::ATTR_W-1:0]*aode_pkg::VAL_W +: aode_pkg::VAL_W];
   assign n_last = aode_pkg::ATTR_W'(cur_ff.n - 1'b1);
   assign p_last = (pa_ff == n_last) && (pb_ff == n_last);
   assign a_last = (ai_ff == cur_ff.n);

   // write port: clearing sweep, or saturating increment in the cycle after the read
   always_comb begin
      if (state_ff == S_INIT || state_ff == S_CLEAR) begin
         pair_we    = 1'b1;
         pair_waddr = sweep_ff;
         pair_wdata = '0;
         attr_we    = (sweep_ff < aode_pkg::PAIR_AW'(aode_pkg::ATTR_RAM_DEPTH));
         attr_waddr = sweep_ff[aode_pkg::ATTR_AW-1:0];
         attr_wdata = '0;
      end else begin
         pair_we    = pwb_v_ff;
         pair_waddr = pwb_addr_ff;
         pair_wdata = (pair_rdata == '1) ? pair_rdata : CW'(pair_rdata + 1'b1);
         attr_we    = awb_v_ff;
         attr_waddr = awb_addr_ff;
         attr_wdata = (attr_rdata == '1) ? attr_rdata : CW'(attr_rdata + 1'b1);
      end
   end

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      pa_in         = pa_ff;
      pb_in         = pb_ff;
      ai_in         = ai_ff;
      prun_in       = prun_ff;
      arun_in       = arun_ff;
      pwb_v_in      = 1'b0;
      awb_v_in      = 1'b0;
      sweep_in      = sweep_ff;
      rd_pair_in    = rd_pair_ff;
      res_count_in  = res_count_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      pop           = 1'b0;
      pair_re       = 1'b0;
      attr_re       = 1'b0;
      pair_raddr    = {pa_ff, va, pb_ff, vb, cur_ff.label};
      if (a_last) begin
         attr_raddr = aode_pkg::ATTR_AW'(aode_pkg::ATTR_DEPTH) |
                      aode_pkg::ATTR_AW'(cur_ff.label);
      end else begin
         attr_raddr = {1'b0, ai_ff[aode_pkg::ATTR_W-1:0], vi, cur_ff.label};
      end
      pwb_addr_in   = pair_raddr;
      awb_addr_in   = attr_raddr;

      unique case (state_ff)
         S_INIT: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (!fifo_empty) begin
               pop           = 1'b1;
               cur_in        = pop_entry;
               res_count_in  = '0;
               res_status_in = aode_pkg::ST_OK;
               pair_raddr    = pop_entry.addr[aode_pkg::PAIR_AW-1:0];
               attr_raddr    = aode_pkg::ATTR_AW'(pop_entry.addr - aode_pkg::PAIR_DEPTH);
               unique case (pop_entry.op)
                  aode_pkg::OP_ADD: begin
                     pa_in    = '0;
                     pb_in    = '0;
                     ai_in    = '0;
                     prun_in  = (pop_entry.n >= aode_pkg::NATTR_W'(2));
                     arun_in  = 1'b1;
                     state_in = S_ADD;
                  end
                  aode_pkg::OP_READ: begin
                     if (pop_entry.addr < aode_pkg::ADDR_IN_W'(aode_pkg::PAIR_DEPTH)) begin
                        rd_pair_in = 1'b1;
                        state_in   = S_READ;
                     end else if (pop_entry.addr <
                                  aode_pkg::ADDR_IN_W'(aode_pkg::ALL_DEPTH)) begin
                        rd_pair_in = 1'b0;
                        state_in   = S_READ;
                     end else begin
                        res_status_in = aode_pkg::ST_BAD_ADDR;
                        state_in      = S_DONE;
                     end
                  end
                  aode_pkg::OP_CLEAR: begin
                     sweep_in = '0;
                     state_in = S_CLEAR;
                  end
                  aode_pkg::OP_DROP: begin
                     res_status_in = aode_pkg::ST_BAD_LABEL;
                     state_in      = S_DONE;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_ADD: begin
            // pair walk and attribute/class walk run side by side
            pair_re  = prun_ff && (pa_ff != pb_ff);
            attr_re  = arun_ff;
            pwb_v_in = pair_re;
            awb_v_in = attr_re;
            if (prun_ff) begin
               if (pb_ff == n_last) begin
                  pb_in = '0;
                  pa_in = pa_ff + 1'b1;
               end else begin
                  pb_in = pb_ff + 1'b1;
               end
               prun_in = !p_last;
            end
            if (arun_ff) begin
               ai_in   = ai_ff + 1'b1;
               arun_in = !a_last;
            end
            if (!prun_in && !arun_in) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_DONE;
         end
         S_READ: begin
            res_count_in = rd_pair_ff ? aode_pkg::OUT_W'(pair_rdata)
                                      : aode_pkg::OUT_W'(attr_rdata);
            state_in = S_DONE;
         end
         S_CLEAR: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == '1) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_count_in  = res_count_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         sweep_ff     <= '0;
         prun_ff      <= 1'b0;
         arun_ff      <= 1'b0;
         pwb_v_ff     <= 1'b0;
         awb_v_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         prun_ff      <= prun_in;
         arun_ff      <= arun_in;
         pwb_v_ff     <= pwb_v_in;
         awb_v_ff     <= awb_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff        <= cur_in;
      pa_ff         <= pa_in;
      pb_ff         <= pb_in;
      ai_ff         <= ai_in;
      pwb_addr_ff   <= pwb_addr_in;
      awb_addr_ff   <= awb_addr_in;
      rd_pair_ff    <= rd_pair_in;
      res_count_ff  <= res_count_in;
      res_status_ff <= res_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      pair_we && pair_re |-> pair_waddr != pair_raddr)
      else $error("pair memory read collides with pending write");
   assert property (@(posedge clock) disable iff (reset)
      attr_we && attr_re |-> attr_waddr != attr_raddr)
      else $error("attribute memory read collides with pending write");
   assert property (@(posedge clock) disable iff (reset)
      init_busy |-> !pop)
      else $error("request taken during clearing pass");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DRAIN |=> !pwb_v_ff && !awb_v_ff)
      else $error("write back still pending after drain");
endmodule
`default_nettype wire

FILE: rtl/aode_pair_class_counter.sv
// top level: front classifier, request queue and count sequencer
// add sample: from pop, the pair and attribute/class walks, a drain of the last write, then the response
// read: memory read, then response; no-op or dropped sample: straight to the response; clear: sweep of the pair memory
// throughput set by the pair walk: one pair read-modify-write per cycle, one request at a time
// reset: synchronous, active high; a clearing pass of the count memories follows, req not ready meanwhile
// registers reset to eight attributes, four classes and full cardinality on every attribute
`default_nettype none
module aode_pair_class_counter (
   input  wire logic clock,
   input  wire logic reset,
   aode_req_if.sink  req_chan,
   aode_rsp_if.source rsp_chan,
   aode_csr_if.sink  csr_chan
);
   // queue handshake between front and back
   logic                push;
   logic                pop;
   logic                fifo_full;
   logic                fifo_empty;
   logic                init_busy;
   aode_pkg::entry_type push_entry;
   aode_pkg::entry_type pop_entry;

   // front: register file, label check, value clamping
   aode_front u_front (
      .clock(clock), .reset(reset), .req(req_chan), .csr(csr_chan),
      .fifo_full(fifo_full), .init_busy(init_busy),
      .push(push), .push_entry(push_entry)
   );

   // short queue lets the front keep accepting while the back works
   aode_fifo u_fifo (
      .clock(clock), .reset(reset),
      .push(push), .push_entry(push_entry), .full(fifo_full),
      .pop(pop), .pop_entry(pop_entry), .empty(fifo_empty)
   );

   // back: memory walks and the response register
   aode_back u_back (
      .clock(clock), .reset(reset),
      .fifo_empty(fifo_empty), .pop_entry(pop_entry), .pop(pop),
      .init_busy(init_busy), .rsp(rsp_chan)
   );
endmodule
`default_nettype wire

FILE: test/tb.sv
// testbench for the aode pair class counter: queued driver, monitor and count predictor
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      aode_pkg::req_kind_type kind;
      logic signed [aode_pkg::VALUE_W-1:0] vals [8];
      logic [aode_pkg::LABEL_IN_W-1:0] label;
      logic [aode_pkg::ADDR_IN_W-1:0] addr;
   } request_type;

   typedef struct {
      logic [aode_pkg::OUT_W-1:0] count;
      aode_pkg::status_type status;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   aode_req_if req_chan ();
   aode_rsp_if rsp_chan ();
   aode_csr_if csr_chan ();

   aode_pair_class_counter dut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source), .csr_chan(csr_chan.sink)
   );

   // predictor copy of the count stores and registers
   logic [31:0] pair_mem [aode_pkg::PAIR_DEPTH];
   logic [31:0] attr_mem [aode_pkg::ATTR_DEPTH];
   logic [31:0] class_mem [aode_pkg::MAX_CLASSES];
   logic [3:0] cfg_nattr;
   logic [2:0] cfg_ncls;
   logic [23:0] cfg_card;

   request_type pending_reqs [$];
   answer_type expected_answers [$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   // accepted request flag, set at the rising edge, used by the driver
   logic req_handshake_seen = 1'b0;

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic void wipe_counts();
      foreach (pair_mem[i]) pair_mem[i] = '0;
      foreach (attr_mem[i]) attr_mem[i] = '0;
      foreach (class_mem[i]) class_mem[i] = '0;
   endfunction

   function automatic logic [2:0] clamp_raw(int attr, logic signed [15:0] raw);
      int card;
      card = int'(cfg_card[3*attr +: 3]) + 1;
      if (raw < 0) return 3'd0;
      if (int'(raw) > card - 1) return 3'(card - 1);
      return 3'(raw);
   endfunction

   function automatic logic [31:0] sat_inc(logic [31:0] c);
      return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
   endfunction

   // apply one request to the count model, queue the answer
   function automatic void count_request(request_type r);
      answer_type ans;
      int n, idx;
      logic [2:0] cv [8];
      ans.count = '0;
      ans.status = aode_pkg::ST_OK;
      case (r.kind)
         aode_pkg::REQ_ADD: begin
            if (r.label >= cfg_ncls || r.label >= aode_pkg::MAX_CLASSES) begin
               ans.status = aode_pkg::ST_BAD_LABEL;
            end else begin
               n = (int'(cfg_nattr) > aode_pkg::MAX_ATTRS) ? aode_pkg::MAX_ATTRS
                                                            : int'(cfg_nattr);
               class_mem[r.label] = sat_inc(class_mem[r.label]);
               for (int a = 0; a < n; a++) begin
                  cv[a] = clamp_raw(a, r.vals[a]);
                  idx = (a*aode_pkg::MAX_CARD + cv[a])*aode_pkg::MAX_CLASSES + r.label;
                  attr_mem[idx] = sat_inc(attr_mem[idx]);
               end
               for (int a = 0; a < n; a++)
                  for (int b = 0; b < n; b++)
                     if (a != b) begin
                        idx = (((a*aode_pkg::MAX_CARD + cv[a])*aode_pkg::MAX_ATTRS + b)
                              *aode_pkg::MAX_CARD + cv[b])*aode_pkg::MAX_CLASSES + r.label;
                        pair_mem[idx] = sat_inc(pair_mem[idx]);
                     end
            end
         end
         aode_pkg::REQ_READ: begin
            if (r.addr < aode_pkg::PAIR_DEPTH) ans.count = pair_mem[r.addr];
            else if (r.addr < aode_pkg::PAIR_DEPTH + aode_pkg::ATTR_DEPTH)
               ans.count = attr_mem[r.addr - aode_pkg::PAIR_DEPTH];
            else if (r.addr < aode_pkg::ALL_DEPTH)
               ans.count = class_mem[r.addr - aode_pkg::PAIR_DEPTH - aode_pkg::ATTR_DEPTH];
            else ans.status = aode_pkg::ST_BAD_ADDR;
         end
         aode_pkg::REQ_CLEAR: wipe_counts();
         default: ;
      endcase
      expected_answers.insert(expected_answers.size(), ans);
   endfunction

   // driver: falling edge, fed from pending_reqs
   always @(negedge clock) begin
      request_type r;
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.req_type <= '0;
         req_chan.value_0 <= '0; req_chan.value_1 <= '0; req_chan.value_2 <= '0;
         req_chan.value_3 <= '0; req_chan.value_4 <= '0; req_chan.value_5 <= '0;
         req_chan.value_6 <= '0; req_chan.value_7 <= '0;
         req_chan.sample_class <= '0;
         req_chan.read_addr <= '0;
         rsp_chan.ready <= 1'b0;
      end else begin
         // only move on once the current request was taken or none is offered
         if (!req_chan.valid || req_handshake_seen) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               r = pending_reqs.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.req_type <= r.kind;
               req_chan.value_0 <= r.vals[0]; req_chan.value_1 <= r.vals[1];
               req_chan.value_2 <= r.vals[2]; req_chan.value_3 <= r.vals[3];
               req_chan.value_4 <= r.vals[4]; req_chan.value_5 <= r.vals[5];
               req_chan.value_6 <= r.vals[6]; req_chan.value_7 <= r.vals[7];
               req_chan.sample_class <= r.label;
               req_chan.read_addr <= r.addr;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      request_type r;
      answer_type got, want;
      req_handshake_seen <= 1'b0;
      if (!reset && req_chan.valid && req_chan.ready) begin
         req_handshake_seen <= 1'b1;
         r.kind = aode_pkg::req_kind_type'(req_chan.req_type);
         r.vals[0] = req_chan.value_0; r.vals[1] = req_chan.value_1;
         r.vals[2] = req_chan.value_2; r.vals[3] = req_chan.value_3;
         r.vals[4] = req_chan.value_4; r.vals[5] = req_chan.value_5;
         r.vals[6] = req_chan.value_6; r.vals[7] = req_chan.value_7;
         r.label = req_chan.sample_class;
         r.addr = req_chan.read_addr;
         count_request(r);
      end
      // monitor: compare each response with the oldest expectation
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.count = rsp_chan.count;
         got.status = aode_pkg::status_type'(rsp_chan.status);
         if (expected_answers.size() == 0) begin
            $error("unexpected response count=%0h status=%0d", got.count, got.status);
            errors++;
         end else begin
            want = expected_answers.pop_front();
            if (got.count !== want.count) begin
               $error("count mismatch: expected %0h actual %0h", want.count, got.count);
               errors++;
            end
            if (got.status !== want.status) begin
               $error("status mismatch: expected %0d actual %0d", want.status, got.status);
               errors++;
            end
         end
      end
   end

   // register write, only while nothing is in flight
   task automatic write_reg(aode_pkg::csr_idx_type idx, logic [23:0] value);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data <= value;
      do @(posedge clock); while (!csr_chan.ready);
      case (idx)
         aode_pkg::CSR_NUM_ATTRIBUTES: cfg_nattr = value[3:0];
         aode_pkg::CSR_NUM_CLASSES: cfg_ncls = value[2:0];
         default: cfg_card = value;
      endcase
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // wait for every queued request to be sent and answered, then a clearing margin
   task automatic drain();
      while (pending_reqs.size() > 0 || req_chan.valid || expected_answers.size() > 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   function automatic logic signed [15:0] pick_value();
      case ($urandom_range(5))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'(signed'($urandom));
         default: return 16'(signed'($urandom_range(9) - 1));
      endcase
   endfunction

   function automatic void queue_req(aode_pkg::req_kind_type k, logic [2:0] lab,
                                     logic [14:0] addr, bit rand_vals);
      request_type r;
      r.kind = k;
      r.label = lab;
      r.addr = addr;
      foreach (r.vals[i]) r.vals[i] = rand_vals ? pick_value() : 16'sd0;
      pending_reqs.insert(pending_reqs.size(), r);
   endfunction

   // address mix: mostly pair counts, then attribute and class counts, the last entry and just past it, any address
   function automatic logic [14:0] pick_addr();
      case ($urandom_range(9))
         0: return 15'($urandom);
         1: return 15'(aode_pkg::ALL_DEPTH - 1 + $urandom_range(2));
         2, 3: return 15'(aode_pkg::PAIR_DEPTH
                          + $urandom_range(aode_pkg::ATTR_DEPTH + aode_pkg::MAX_CLASSES - 1));
         default: return 15'($urandom_range(aode_pkg::PAIR_DEPTH - 1));
      endcase
   endfunction

   initial begin
      logic [23:0] card_sets [4];
      request_type r;
      csr_chan.valid = 1'b0;
      csr_chan.index = '0;
      csr_chan.data = '0;
      card_sets[0] = 24'hFFFFFF;
      card_sets[1] = 24'h000000;
      card_sets[2] = 24'h249249;
      cfg_nattr = 4'd8;
      cfg_ncls = 3'd4;
      cfg_card = 24'hFFFFFF;
      wipe_counts();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every request kind, bad label, bad address, no-op
      for (int i = 0; i < 2; i++) begin
         r.kind = aode_pkg::REQ_ADD;
         r.label = 3'(i);
         r.addr = '0;
         foreach (r.vals[j]) r.vals[j] = i ? 16'sh7FFF : 16'sh8000;
         pending_reqs.insert(pending_reqs.size(), r);
      end
      queue_req(aode_pkg::REQ_ADD, 3'd3, '0, 1);
      queue_req(aode_pkg::REQ_ADD, 3'd4, '0, 1);
      queue_req(aode_pkg::REQ_ADD, 3'd7, '0, 1);
      queue_req(aode_pkg::REQ_READ, '0, 15'(aode_pkg::ALL_DEPTH - 1), 0);
      queue_req(aode_pkg::REQ_READ, '0, 15'(aode_pkg::ALL_DEPTH), 0);
      queue_req(aode_pkg::REQ_READ, '0, 15'h7FFF, 0);
      queue_req(aode_pkg::REQ_READ, '0, 15'(aode_pkg::PAIR_DEPTH), 0);
      queue_req(aode_pkg::REQ_READ, '0, 15'(((0*8+7)*8+1)*8*4 + 7*4 + 1), 0);
      queue_req(aode_pkg::REQ_READ, '0, 15'd0, 0);
      queue_req(aode_pkg::REQ_NOP, 3'd7, 15'h7FFF, 1);
      queue_req(aode_pkg::REQ_CLEAR, '0, '0, 0);
      queue_req(aode_pkg::REQ_READ, '0, 15'(aode_pkg::ALL_DEPTH - 4), 0);
      drain();

      // random phases over several settings and idling patterns
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 85; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 85; end
            default: begin send_idle_pct = 19; recv_stall_pct = 19; end
         endcase
         card_sets[3] = 24'($urandom);
         write_reg(aode_pkg::CSR_NUM_ATTRIBUTES,
                   (ph == 1) ? 24'd15 : 24'($urandom_range(8)));
         write_reg(aode_pkg::CSR_NUM_CLASSES, (ph == 2) ? 24'd7 : 24'($urandom_range(4)));
         write_reg(aode_pkg::CSR_CARD_TABLE, card_sets[ph % 4]);
         for (int i = 0; i < 190; i++) begin
            case ($urandom_range(19))
               0: queue_req(aode_pkg::REQ_NOP, 3'($urandom), 15'($urandom), 1);
               1: if ($urandom_range(3) == 0) queue_req(aode_pkg::REQ_CLEAR, '0, '0, 0);
                  else queue_req(aode_pkg::REQ_NOP, '0, '0, 0);
               2, 3, 4, 5, 6, 7, 8:
                  queue_req(aode_pkg::REQ_READ, 3'($urandom), pick_addr(), 1);
               default: queue_req(aode_pkg::REQ_ADD,
                  ($urandom_range(7) == 0) ? 3'($urandom) : 3'($urandom_range(3)), '0, 1);
            endcase
         end
         drain();
      end
      write_reg(aode_pkg::CSR_NUM_ATTRIBUTES, 24'd8);
      write_reg(aode_pkg::CSR_NUM_CLASSES, 24'd4);

      drain();
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #100ms;
      $display("Simulation FAILED");
      $finish;
   end
endmodule
`default_nettype wire
